### rtl/srpg_pkg.sv
package srpg_pkg;

    // Command codes carried in req_type
    localparam logic [2:0] REQ_TICK        = 3'd0;
    localparam logic [2:0] REQ_MOVE        = 3'd1;
    localparam logic [2:0] REQ_ROT_CENTER  = 3'd2;
    localparam logic [2:0] REQ_ROT_WHEEL   = 3'd3;
    localparam logic [2:0] REQ_RAMP_WRITE  = 3'd4;

    // Reciprocal divide: quotient = (x * mul) >> DIV_SHIFT, exact for 16-bit x
    localparam int DIV_SHIFT = 24;
    localparam int DIV_MUL_W = 25;
    localparam int DIV_PROD_W = 16 + DIV_MUL_W;

    // Status snapshot carried by one result item
    typedef struct packed {
        logic        step_a;
        logic        step_b;
        logic        dir_a;
        logic        dir_b;
        logic        mode_pins;
        logic        busy_res;
        logic [15:0] current_period;
        logic [15:0] remaining_steps;
    } res_t;

endpackage

### rtl/srpg_if.sv
interface srpg_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [15:0] step_count;
    logic        direction;
    logic        wheel_select;
    logic [3:0]  ramp_index;
    logic [15:0] ramp_period;

    modport source (
        output valid, req_type, step_count, direction, wheel_select,
               ramp_index, ramp_period,
        input  ready
    );
    modport sink (
        input  valid, req_type, step_count, direction, wheel_select,
               ramp_index, ramp_period,
        output ready
    );
endinterface

interface srpg_res_if;
    logic        valid;
    logic        ready;
    logic        step_a;
    logic        step_b;
    logic        dir_a;
    logic        dir_b;
    logic        mode_pins;
    logic        busy_res;
    logic [15:0] current_period;
    logic [15:0] remaining_steps;

    modport source (
        output valid, step_a, step_b, dir_a, dir_b, mode_pins, busy_res,
               current_period, remaining_steps,
        input  ready
    );
    modport sink (
        input  valid, step_a, step_b, dir_a, dir_b, mode_pins, busy_res,
               current_period, remaining_steps,
        output ready
    );
endinterface

### rtl/stepper_ramp_pulse_generator_unit.sv
// Two-motor step pulse generator with a table-driven trapezoidal ramp.
// Channel cmd carries one item per tick or command: timer ticks, motion
// commands (straight, rotate about center, rotate about one wheel) and
// ramp table writes. Channel res returns exactly one status item per
// command item: step, direction and mode pin levels, busy flag, period
// in effect and steps remaining, all taken after that item's update.
// cfg_we/cfg_wdata set full-step mode; write it only while idle.
// One item per cycle while res does not stall. An accepted item passes
// the stage register and then the output register before it shows on
// res. The ramp table sits in a synchronous RAM with a registered read;
// a period fetched by one item is forwarded from the read register to
// the next item's timer compare, so back-to-back ticks never wait.
// The period index divide is a reciprocal multiply in the accept cycle.
// Reset clears the motion state and enables both motors; the ramp table
// is not cleared and must be written before a motion starts.
// When res stalls, one result waits in the output register and one more
// item is taken into the stage behind it; cmd then drops ready.
module stepper_ramp_pulse_generator_unit #(
    parameter int RAMP_STAGES   = 16,
    parameter int RAMP_INTERVAL = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    srpg_cmd_if.sink       cmd,
    srpg_res_if.source     res,
    input  logic           cfg_we,
    input  logic           cfg_wdata
);
    import srpg_pkg::*;

    localparam int ADDR_W = (RAMP_STAGES > 1) ? $clog2(RAMP_STAGES) : 1;
    localparam logic [16:0] RAMP_SPAN = 17'(RAMP_STAGES * RAMP_INTERVAL);
    localparam logic [DIV_MUL_W-1:0] DIV_MUL =
        DIV_MUL_W'(((1 << DIV_SHIFT) + RAMP_INTERVAL - 1) / RAMP_INTERVAL);

    // Architectural state
    logic [15:0] steps_left_reg, steps_left_next;
    logic [15:0] steps_done_reg, steps_done_next;
    logic [1:0]  motor_en_reg, motor_en_next;
    logic [1:0]  step_pins_reg, step_pins_next;
    logic [1:0]  dir_pins_reg, dir_pins_next;
    logic [15:0] period_reg, period_next;
    logic [15:0] timer_reg, timer_next;
    logic        running_reg, running_next;
    logic        mode_reg;

    // Ramp RAM and its read register
    logic [15:0]       ramp_mem [RAMP_STAGES];
    logic [15:0]       rd_data_reg;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;

    // Pipeline: stage behind the output, then the output register
    logic        s1_valid_reg;
    logic        s1_pend_reg;
    res_t        s1_res_reg;
    res_t        s1_out;
    logic        out_valid_reg;
    res_t        out_res_reg;

    logic        accept;
    logic        s1_advance;
    logic [15:0] eff_period;
    logic [16:0] timer_inc;
    logic        ramp_acc;
    logic        ramp_dec;
    logic [15:0] div_in;
    logic [DIV_PROD_W-1:0] div_prod;
    logic [7:0]  wr_idx8;

    assign s1_advance = s1_valid_reg && (!out_valid_reg || res.ready);
    assign cmd.ready  = !s1_valid_reg || s1_advance;
    assign accept     = cmd.valid && cmd.ready;

    // Forward a period still sitting in the RAM read register
    assign eff_period = s1_pend_reg ? rd_data_reg : period_reg;

    assign wr_idx8 = 8'(cmd.ramp_index);
    assign wr_addr = wr_idx8[ADDR_W-1:0];

    // Divide the chosen step count by the ramp interval
    assign div_prod = DIV_PROD_W'(div_in) * DIV_PROD_W'(DIV_MUL);

    // Next state for one accepted item
    always_comb
    begin
        steps_left_next = steps_left_reg;
        steps_done_next = steps_done_reg;
        motor_en_next   = motor_en_reg;
        step_pins_next  = step_pins_reg;
        dir_pins_next   = dir_pins_reg;
        timer_next      = timer_reg;
        running_next    = running_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        timer_inc       = {1'b0, timer_reg} + 17'd1;
        ramp_acc        = 1'b0;
        ramp_dec        = 1'b0;
        div_in          = '0;
        case (cmd.req_type)
            REQ_TICK:
            begin
                if (running_reg)
                begin
                    if (timer_inc >= {1'b0, eff_period})
                    begin
                        timer_next = '0;
                        if (steps_left_reg == 16'd0)
                        begin
                            // stop and reload the first ramp entry
                            running_next   = 1'b0;
                            step_pins_next = 2'b00;
                            rd_en          = 1'b1;
                        end
                        else
                        begin
                            if (step_pins_reg != 2'b00)
                            begin
                                step_pins_next = 2'b00;
                            end
                            else
                            begin
                                step_pins_next  = motor_en_reg;
                                steps_left_next = steps_left_reg - 16'd1;
                                steps_done_next = steps_done_reg + 16'd1;
                            end
                            ramp_acc = ({1'b0, steps_done_next} < RAMP_SPAN) &&
                                       (steps_done_next < steps_left_next);
                            ramp_dec = ({1'b0, steps_left_next} < RAMP_SPAN) &&
                                       (steps_left_next <= steps_done_next);
                            div_in   = ramp_acc ? steps_done_next : steps_left_next;
                            rd_en    = ramp_acc || ramp_dec;
                            rd_addr  = div_prod[DIV_SHIFT +: ADDR_W];
                        end
                    end
                    else
                    begin
                        timer_next = timer_inc[15:0];
                    end
                end
            end
            REQ_MOVE, REQ_ROT_CENTER, REQ_ROT_WHEEL:
            begin
                if (cmd.req_type == REQ_MOVE)
                begin
                    dir_pins_next = cmd.direction ? 2'b10 : 2'b01;
                    motor_en_next = 2'b11;
                end
                else if (cmd.req_type == REQ_ROT_CENTER)
                begin
                    dir_pins_next = cmd.direction ? 2'b00 : 2'b11;
                    motor_en_next = 2'b11;
                end
                else
                begin
                    dir_pins_next = cmd.direction ? 2'b00 : 2'b11;
                    motor_en_next = cmd.wheel_select ? 2'b10 : 2'b01;
                end
                steps_left_next = cmd.step_count;
                steps_done_next = '0;
                timer_next      = '0;
                running_next    = 1'b1;
                rd_en           = 1'b1;
            end
            REQ_RAMP_WRITE:
            begin
                wr_en = (int'(cmd.ramp_index) < RAMP_STAGES);
            end
            default:
            begin
                // unknown request: hold everything
            end
        endcase
    end

    // Commit a fetched period once it is in the read register
    always_comb
    begin
        period_next = period_reg;
        if (s1_valid_reg && s1_pend_reg)
        begin
            period_next = rd_data_reg;
        end
    end

    // Ramp RAM: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (accept && wr_en)
        begin
            ramp_mem[wr_addr] <= cmd.ramp_period;
        end
        if (accept && rd_en)
        begin
            rd_data_reg <= ramp_mem[rd_addr];
        end
    end

    // Advance the motion state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_left_reg <= '0;
            steps_done_reg <= '0;
            motor_en_reg   <= 2'b11;
            step_pins_reg  <= '0;
            dir_pins_reg   <= '0;
            timer_reg      <= '0;
            running_reg    <= 1'b0;
            period_reg     <= '0;
            mode_reg       <= 1'b0;
        end
        else
        begin
            period_reg <= period_next;
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            if (accept)
            begin
                steps_left_reg <= steps_left_next;
                steps_done_reg <= steps_done_next;
                motor_en_reg   <= motor_en_next;
                step_pins_reg  <= step_pins_next;
                dir_pins_reg   <= dir_pins_next;
                timer_reg      <= timer_next;
                running_reg    <= running_next;
            end
        end
    end

    // Pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                s1_pend_reg  <= rd_en;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
                s1_pend_reg  <= 1'b0;
            end
            if (s1_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Resolve the period of the item leaving the stage
    always_comb
    begin
        s1_out                = s1_res_reg;
        s1_out.current_period = eff_period;
    end

    // Snapshot the status; the period is resolved on the way out
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_res_reg.step_a          <= step_pins_next[0];
            s1_res_reg.step_b          <= step_pins_next[1];
            s1_res_reg.dir_a           <= dir_pins_next[0];
            s1_res_reg.dir_b           <= dir_pins_next[1];
            s1_res_reg.mode_pins       <= mode_reg;
            s1_res_reg.busy_res        <= running_next;
            s1_res_reg.current_period  <= '0;
            s1_res_reg.remaining_steps <= steps_left_next;
        end
        if (s1_advance)
        begin
            out_res_reg <= s1_out;
        end
    end

    // Drive the result channel
    assign res.valid           = out_valid_reg;
    assign res.step_a          = out_res_reg.step_a;
    assign res.step_b          = out_res_reg.step_b;
    assign res.dir_a           = out_res_reg.dir_a;
    assign res.dir_b           = out_res_reg.dir_b;
    assign res.mode_pins       = out_res_reg.mode_pins;
    assign res.busy_res        = out_res_reg.busy_res;
    assign res.current_period  = out_res_reg.current_period;
    assign res.remaining_steps = out_res_reg.remaining_steps;

endmodule

### rtl/srpg_port_chk.sv
module srpg_port_chk (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        res_valid,
    input  logic        res_ready,
    input  logic        step_a,
    input  logic        step_b,
    input  logic        busy_res,
    input  logic [15:0] current_period,
    input  logic [15:0] remaining_steps
);

    // A stalled result stays offered
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(current_period) &&
            $stable(remaining_steps) && $stable(busy_res))
        else $error("result payload changed while stalled");

    // An idle block drives no step pulse
    a_idle_pins: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !busy_res |-> !step_a && !step_b)
        else $error("step pin high while idle");

    // An idle block has no steps left
    a_idle_steps: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !busy_res |-> remaining_steps == 16'd0)
        else $error("steps remaining while idle");

endmodule

bind stepper_ramp_pulse_generator_unit srpg_port_chk u_srpg_port_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (res.valid),
    .res_ready       (res.ready),
    .step_a          (res.step_a),
    .step_b          (res.step_b),
    .busy_res        (res.busy_res),
    .current_period  (res.current_period),
    .remaining_steps (res.remaining_steps)
);
